>>> design/p3c_pkg.sv
// Shared types, constants and helpers for the POP3 command line checker.
`default_nettype none

package p3c_pkg;

    localparam int ARG_MAX_DEF = 40;
    localparam int LEN_W       = 6;
    localparam int JQ_DEPTH    = 2;
    localparam int JQ_AW       = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FIRST  = 8'h21;
    localparam logic [7:0] CH_LAST   = 8'h7E;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_USER = 2'd0;
    localparam t_cmd CMD_PASS = 2'd1;
    localparam t_cmd CMD_STAT = 2'd2;
    localparam t_cmd CMD_NOOP = 2'd3;

    typedef logic [1:0] t_ses;
    localparam t_ses SES_AUTH  = 2'd0;
    localparam t_ses SES_PASS  = 2'd1;
    localparam t_ses SES_TRANS = 2'd2;

    typedef logic [2:0] t_verdict;
    localparam t_verdict V_OK          = 3'd0;
    localparam t_verdict V_INVALID     = 3'd1;
    localparam t_verdict V_LOGGED_IN   = 3'd2;
    localparam t_verdict V_MUST_LOGIN  = 3'd3;
    localparam t_verdict V_USER_FIRST  = 3'd4;
    localparam t_verdict V_USER_PICKED = 3'd5;
    localparam t_verdict V_NO_USER     = 3'd6;
    localparam t_verdict V_NO_PASS     = 3'd7;

    // one finished line, handed from the parser to the emitter
    typedef struct packed {
        t_verdict         verdict;
        t_cmd             cmd;
        logic             arg_present;
        logic [LEN_W-1:0] len;
    } t_job;

    typedef struct packed {
        logic             is_verdict;
        logic [7:0]       arg_char;
        t_verdict         verdict;
        t_cmd             cmd;
        logic             arg_present;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_res;

    function automatic logic [7:0] cmd_letter(input t_cmd cmd, input logic [1:0] pos);
        logic [7:0] ch;
        case ({cmd, pos})
            {CMD_USER, 2'd0}: ch = "U";
            {CMD_USER, 2'd1}: ch = "S";
            {CMD_USER, 2'd2}: ch = "E";
            {CMD_USER, 2'd3}: ch = "R";
            {CMD_PASS, 2'd0}: ch = "P";
            {CMD_PASS, 2'd1}: ch = "A";
            {CMD_PASS, 2'd2}: ch = "S";
            {CMD_PASS, 2'd3}: ch = "S";
            {CMD_STAT, 2'd0}: ch = "S";
            {CMD_STAT, 2'd1}: ch = "T";
            {CMD_STAT, 2'd2}: ch = "A";
            {CMD_STAT, 2'd3}: ch = "T";
            {CMD_NOOP, 2'd0}: ch = "N";
            {CMD_NOOP, 2'd1}: ch = "O";
            {CMD_NOOP, 2'd2}: ch = "O";
            {CMD_NOOP, 2'd3}: ch = "P";
            default:          ch = 8'h00;
        endcase
        return ch;
    endfunction

    // phase check; STAT and NOOP fall in one class
    function automatic t_verdict judge(input t_ses ses, input t_cmd cmd, input logic arg_given);
        t_cmd     cs;
        t_verdict v;
        cs = (cmd == CMD_USER || cmd == CMD_PASS) ? cmd : CMD_STAT;
        if (ses == SES_TRANS && cs != CMD_STAT)
            v = V_LOGGED_IN;
        else if (ses != SES_TRANS && cs == CMD_STAT)
            v = V_MUST_LOGIN;
        else if (ses == SES_AUTH && cs == CMD_PASS)
            v = V_USER_FIRST;
        else if (ses == SES_PASS && cs == CMD_USER)
            v = V_USER_PICKED;
        else if (ses != cs)
            v = V_INVALID;
        else if (cs == CMD_USER && !arg_given)
            v = V_NO_USER;
        else if (cs == CMD_PASS && !arg_given)
            v = V_NO_PASS;
        else
            v = V_OK;
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/pop3_command_line_checker_unit.sv
// POP3 command line checker: byte parser, job queue, argument RAM and result emitter.
// Takes one command-line byte per cycle while parsing and full is low. A finished line
// is queued (two entries) for the emitter, which takes the line from the queue, then for
// each argument character reads the RAM and loads the byte into the output register, and
// last emits the verdict word; a stalled result side holds it. The emitter takes no new
// line from the queue until it has emitted the verdict of the last one.
// The input reports full when the job queue is full, or while the parser sits in an
// argument and the previous line's argument is still being read out of the shared
// argument RAM. No clearing pass after reset: the block takes bytes at once.
`default_nettype none

module pop3_command_line_checker_unit
    import p3c_pkg::*;
#(
    parameter int ARG_MAX = ARG_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_end_of_data,
    input  wire logic [1:0]       i_session,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  o_is_verdict,
    output logic      [7:0]       o_arg_char,
    output logic      [2:0]       o_verdict,
    output logic      [1:0]       o_command_id,
    output logic                  o_arg_present,
    output logic      [LEN_W-1:0] o_arg_length,
    output logic                  o_last
);

    localparam int AW = (ARG_MAX > 1) ? $clog2(ARG_MAX) : 1;

    logic          q_push, q_full, q_pop, q_empty;
    t_job          q_in, q_out;
    logic          wr_en, rd_en, arg_done, res_vld;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    t_res          res;

    p3c_front #(.ARG_MAX(ARG_MAX)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .i_session     (i_session),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_job_push    (q_push),
        .o_job         (q_in),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_arg_done    (arg_done)
    );

    p3c_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    p3c_ram #(.WIDTH(8), .DEPTH(ARG_MAX)) u_arg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    p3c_back #(.ARG_MAX(ARG_MAX)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (q_out),
        .o_q_pop    (q_pop),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_arg_done (arg_done),
        .i_pop      (pop),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    assign empty         = !res_vld;
    assign o_is_verdict  = res.is_verdict;
    assign o_arg_char    = res.arg_char;
    assign o_verdict     = res.verdict;
    assign o_command_id  = res.cmd;
    assign o_arg_present = res.arg_present;
    assign o_arg_length  = res.len;
    assign o_last        = res.last;

endmodule

`default_nettype wire

>>> design/p3c_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module p3c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en)
            o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> design/p3c_front.sv
// Front end: parses command-line bytes, stores argument bytes, queues line results.
`default_nettype none

module p3c_front
    import p3c_pkg::*;
#(
    parameter int ARG_MAX = ARG_MAX_DEF,
    localparam int AW     = (ARG_MAX > 1) ? $clog2(ARG_MAX) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_end_of_data,
    input  wire logic [1:0]    i_session,
    output logic               o_full,
    input  wire logic          i_q_full,
    output logic               o_job_push,
    output t_job               o_job,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data,
    input  wire logic          i_arg_done
);

    localparam logic [3:0] PH_NAME  = 4'd0;
    localparam logic [3:0] PH_AFTER = 4'd1;
    localparam logic [3:0] PH_ARG   = 4'd2;
    localparam logic [3:0] PH_CR    = 4'd3;
    localparam logic [3:0] PH_LF    = 4'd4;
    localparam logic [3:0] PH_DROP  = 4'd5;

    logic [3:0]       r_phase, n_phase;
    logic [1:0]       r_pos, n_pos;
    logic [3:0]       r_cand, n_cand;
    t_cmd             r_cmd, n_cmd;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ag, n_ag;
    logic             r_busy;

    logic       accept, step_bad, step_done, is_letter, wr_en;
    logic [7:0] up;
    logic [3:0] match;
    t_cmd       pick;

    // argument RAM is shared with the emitter: hold off new argument bytes
    // until the previous line's argument has been read out
    assign o_full = i_q_full || (r_phase == PH_ARG && r_busy);
    assign accept = i_push && !o_full;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_cand    = r_cand;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_ag      = r_ag;
        step_bad  = 1'b0;
        step_done = 1'b0;
        wr_en     = 1'b0;
        is_letter = (i_data_byte >= "A" && i_data_byte <= "Z") ||
                    (i_data_byte >= "a" && i_data_byte <= "z");
        up        = i_data_byte & CASE_MASK;
        for (int i = 0; i < 4; i++)
            match[i] = r_cand[i] && (cmd_letter(t_cmd'(i), r_pos) == up);
        pick = CMD_USER;
        for (int i = 3; i >= 0; i--)
            if (match[i])
                pick = t_cmd'(i);

        case (r_phase)
            PH_NAME: begin
                n_cand = match;
                if (!is_letter || match == 4'd0) begin
                    step_bad = 1'b1;
                end else if (r_pos == 2'd3) begin
                    n_cmd   = pick;
                    n_phase = (pick == CMD_USER || pick == CMD_PASS) ? PH_AFTER : PH_CR;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            PH_AFTER: begin
                if (i_data_byte == CH_CR)
                    n_phase = PH_LF;
                else if (i_data_byte == CH_SPACE)
                    n_phase = PH_ARG;
                else
                    step_bad = 1'b1;
            end
            PH_ARG: begin
                if (i_data_byte == CH_SPACE || i_data_byte == CH_CR) begin
                    if (r_len == '0 || i_data_byte == CH_SPACE) begin
                        step_bad = 1'b1;
                    end else begin
                        n_ag    = 1'b1;
                        n_phase = PH_LF;
                    end
                end else if (i_data_byte < CH_FIRST || i_data_byte > CH_LAST ||
                             r_len >= LEN_W'(ARG_MAX)) begin
                    step_bad = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    n_len = r_len + LEN_W'(1);
                    if (r_len == LEN_W'(ARG_MAX - 1)) begin
                        n_ag    = 1'b1;
                        n_phase = PH_CR;
                    end
                end
            end
            PH_CR: begin
                if (i_data_byte == CH_CR)
                    n_phase = PH_LF;
                else
                    step_bad = 1'b1;
            end
            PH_LF: begin
                if (i_data_byte == CH_LF)
                    step_done = 1'b1;
                else
                    step_bad = 1'b1;
            end
            default: step_bad = 1'b1;
        endcase
    end

    assign o_job_push = accept && r_phase != PH_DROP &&
                        (step_bad || step_done || i_end_of_data);

    always_comb begin
        if (step_done) begin
            o_job.verdict     = judge(i_session, r_cmd, r_ag);
            o_job.cmd         = r_cmd;
            o_job.arg_present = r_ag;
            o_job.len         = r_len;
        end else begin
            o_job.verdict     = V_INVALID;
            o_job.cmd         = CMD_USER;
            o_job.arg_present = 1'b0;
            o_job.len         = '0;
        end
    end

    assign o_wr_en   = accept && wr_en && r_phase != PH_DROP;
    assign o_wr_addr = r_len[AW-1:0];
    assign o_wr_data = i_data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME;
            r_pos   <= '0;
            r_cand  <= 4'hF;
            r_cmd   <= CMD_USER;
            r_len   <= '0;
            r_ag    <= 1'b0;
        end else if (accept) begin
            if (r_phase == PH_DROP || o_job_push) begin
                if (i_end_of_data) begin
                    r_phase <= PH_NAME;
                    r_pos   <= '0;
                    r_cand  <= 4'hF;
                    r_cmd   <= CMD_USER;
                    r_len   <= '0;
                    r_ag    <= 1'b0;
                end else begin
                    r_phase <= PH_DROP;
                end
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_cand  <= n_cand;
                r_cmd   <= n_cmd;
                r_len   <= n_len;
                r_ag    <= n_ag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_busy <= 1'b0;
        else if (o_job_push && o_job.len != '0)
            r_busy <= 1'b1;
        else if (i_arg_done)
            r_busy <= 1'b0;
    end

endmodule

`default_nettype wire

>>> design/p3c_jobq.sv
// Short queue of finished-line words between parser and emitter.
`default_nettype none

module p3c_jobq
    import p3c_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wp, r_rp;
    logic [JQ_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (JQ_AW + 1)'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_job;
    end

    // depth is a power of two, pointers wrap naturally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + JQ_AW'(1);
            if (i_pop)
                r_rp <= r_rp + JQ_AW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + (JQ_AW + 1)'(1);
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - (JQ_AW + 1)'(1);
        end
    end

endmodule

`default_nettype wire

>>> design/p3c_back.sv
// Back end: reads the argument out of RAM and emits argument and verdict words.
`default_nettype none

module p3c_back
    import p3c_pkg::*;
#(
    parameter int ARG_MAX = ARG_MAX_DEF,
    localparam int AW     = (ARG_MAX > 1) ? $clog2(ARG_MAX) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire t_job          i_job,
    output logic               o_q_pop,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [7:0]    i_rd_data,
    output logic               o_arg_done,
    input  wire logic          i_pop,
    output logic               o_res_vld,
    output t_res               o_res
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;
    localparam logic [1:0] B_VERD = 2'd3;

    logic [1:0]       r_state, n_state;
    t_job             r_job, n_job;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_out_vld, n_out_vld;
    t_res             r_out, n_out;
    logic             out_free;

    assign out_free = !r_out_vld || i_pop;

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_idx      = r_idx;
        n_out_vld  = r_out_vld && !i_pop;
        n_out      = r_out;
        o_q_pop    = 1'b0;
        o_rd_en    = 1'b0;
        o_arg_done = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_job   = i_job;
                    n_idx   = '0;
                    n_state = (i_job.len == '0) ? B_VERD : B_READ;
                end
            end
            B_READ: begin
                o_rd_en = 1'b1;
                n_state = B_LOAD;
            end
            B_LOAD: begin
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.is_verdict  = 1'b0;
                    n_out.arg_char    = i_rd_data;
                    n_out.verdict     = V_OK;
                    n_out.cmd         = r_job.cmd;
                    n_out.arg_present = 1'b1;
                    n_out.len         = r_job.len;
                    n_out.last        = 1'b0;
                    if (r_idx + LEN_W'(1) == r_job.len) begin
                        o_arg_done = 1'b1;
                        n_state    = B_VERD;
                    end else begin
                        n_idx   = r_idx + LEN_W'(1);
                        n_state = B_READ;
                    end
                end
            end
            B_VERD: begin
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.is_verdict  = 1'b1;
                    n_out.arg_char    = 8'h00;
                    n_out.verdict     = r_job.verdict;
                    n_out.cmd         = r_job.cmd;
                    n_out.arg_present = r_job.arg_present;
                    n_out.len         = r_job.len;
                    n_out.last        = 1'b1;
                    n_state           = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_rd_addr = r_idx[AW-1:0];
    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

>>> design/p3c_checker.sv
// Port-level checker for the command line checker, bound to the top level.
`default_nettype none

module p3c_checker
    import p3c_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic             o_is_verdict,
    input wire logic [7:0]       o_arg_char,
    input wire logic [2:0]       o_verdict,
    input wire logic             o_arg_present,
    input wire logic [LEN_W-1:0] o_arg_length,
    input wire logic             o_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("not idle after reset");

    a_last_is_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_last == o_is_verdict)
        else $error("last does not mark the verdict word");

    a_arg_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_is_verdict |-> o_arg_present && o_verdict == V_OK &&
                                    o_arg_length != '0)
        else $error("argument word fields wrong");

    a_arg_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_is_verdict |-> o_arg_char >= CH_FIRST && o_arg_char <= CH_LAST)
        else $error("argument character not printable");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_arg_char) && $stable(o_is_verdict) &&
                           $stable(o_verdict))
        else $error("waiting word changed");

endmodule

bind pop3_command_line_checker_unit p3c_checker u_p3c_checker (.*);

`default_nettype wire
